/* rtl/lcdsb_pkg.sv */
// Shared types and constants for the character LCD shadow buffer.
`default_nettype none

package lcdsb_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS_DEF    = 2;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [7:0]  SPACE_GLYPH  = 8'h20;
  localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
  localparam logic [7:0]  LCD_SET_ADDR = 8'h80;
  localparam logic [31:0] RECIP_10     = 32'hCCCC_CCCD;

  localparam logic [7:0] BLINK_GLYPH_RST = 8'h20;
  localparam logic [7:0] PAD_GLYPH_RST   = 8'h20;
  localparam logic [7:0] PLUS_GLYPH_RST  = 8'h2B;
  localparam logic [7:0] MINUS_GLYPH_RST = 8'h2D;
  localparam logic [7:0] POINT_GLYPH_RST = 8'h2E;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_TOGGLE    = 3'd1,
    CMD_PUT       = 3'd2,
    CMD_BLINK_RUN = 3'd3,
    CMD_BLINK_CLR = 3'd4,
    CMD_UNSIGNED  = 3'd5,
    CMD_DECIMAL   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_TOGGLE    = 3'd1,
    OP_PUT       = 3'd2,
    OP_BLINK_RUN = 3'd3,
    OP_BLINK_CLR = 3'd4,
    OP_NUM_U     = 3'd5,
    OP_NUM_D     = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    CFG_BLINK = 3'd0,
    CFG_PAD   = 3'd1,
    CFG_PLUS  = 3'd2,
    CFG_MINUS = 3'd3,
    CFG_POINT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  column;
    logic        row;
    logic [7:0]  glyph;
    logic [4:0]  count;
    logic [3:0]  decimals;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] lcd_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  column;
    logic        row;
    logic [7:0]  glyph;
    logic [4:0]  count;
    logic [3:0]  decimals;
    logic        neg;
    logic [31:0] mag;
  } op_t;

  typedef struct packed {
    logic [7:0] blink;
    logic [7:0] pad;
    logic [7:0] plus;
    logic [7:0] minus;
    logic [7:0] point;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/char_lcd_shadow_buffer_refresh.sv */
// Top level of the character LCD shadow buffer with refresh scanner.
//
//   channel   direction  handshake              payload
//   command   in         push / full            in_i  (lcdsb_pkg::in_t)
//   result    out        empty / pop            res_o (lcdsb_pkg::out_t)
//   config    in         cfg_we_i, cfg_idx_i    cfg_wdata_i
//
// Glyph writes, blink commands and clean ticks complete in the back end's idle state;
// a dirty tick reads the cell, then sends the address byte and the data byte, and
// stalls while the result queue is full. A number write passes each digit through
// the reciprocal multiplier, with a state for the separator and for each pad place.
// Reset is asynchronous; the glyph store needs no clearing pass.
// A full result queue stalls the back end; the command queue takes two more transfers.
`default_nettype none

module char_lcd_shadow_buffer_refresh #(
  parameter int COLUMNS = lcdsb_pkg::COLUMNS_DEF,
  parameter int ROWS    = lcdsb_pkg::ROWS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire lcdsb_pkg::in_t in_i,
  output logic                empty,
  input  wire logic           pop,
  output lcdsb_pkg::out_t     res_o,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [7:0]     cfg_wdata_i
);

  lcdsb_pkg::cfg_t cfg_q;
  lcdsb_pkg::op_t  op;
  lcdsb_pkg::out_t res_wdata;
  logic            op_empty, op_pop;
  logic            res_push, res_full;
  logic [$bits(lcdsb_pkg::out_t)-1:0] res_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink <= lcdsb_pkg::BLINK_GLYPH_RST;
      cfg_q.pad   <= lcdsb_pkg::PAD_GLYPH_RST;
      cfg_q.plus  <= lcdsb_pkg::PLUS_GLYPH_RST;
      cfg_q.minus <= lcdsb_pkg::MINUS_GLYPH_RST;
      cfg_q.point <= lcdsb_pkg::POINT_GLYPH_RST;
    end else if (cfg_we_i) begin
      case (lcdsb_pkg::cfg_idx_e'(cfg_idx_i))
        lcdsb_pkg::CFG_BLINK: cfg_q.blink <= cfg_wdata_i;
        lcdsb_pkg::CFG_PAD:   cfg_q.pad   <= cfg_wdata_i;
        lcdsb_pkg::CFG_PLUS:  cfg_q.plus  <= cfg_wdata_i;
        lcdsb_pkg::CFG_MINUS: cfg_q.minus <= cfg_wdata_i;
        lcdsb_pkg::CFG_POINT: cfg_q.point <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  lcdsb_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_i       (in_i),
    .op_pop_i   (op_pop),
    .op_empty_o (op_empty),
    .op_o       (op)
  );

  lcdsb_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .cfg_i      (cfg_q),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_wdata)
  );

  lcdsb_fifo #(
    .W     ($bits(lcdsb_pkg::out_t)),
    .DEPTH (lcdsb_pkg::FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .empty_o (empty)
  );

  assign res_o = lcdsb_pkg::out_t'(res_raw);

`ifndef ASSERT_OFF
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result transfer into a full queue");

  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_wdata.register_select == res_wdata.last))
    else $error("last flag does not match byte kind");

  a_cmd_is_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res_wdata.register_select) |-> res_wdata.lcd_byte[7])
    else $error("command byte is not a set-address");

  a_cmd_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res_wdata.register_select) |=>
      !(res_push && !res_wdata.register_select))
    else $error("two command bytes in a row");
`endif

endmodule

`default_nettype wire

/* rtl/lcdsb_fifo.sv */
// Small register FIFO used between the block's stages.
`default_nettype none

module lcdsb_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = lcdsb_pkg::FIFO_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      rdata_o,
  output logic              empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/lcdsb_front.sv */
// Front end: takes command items, classifies them and queues the work.
`default_nettype none

module lcdsb_front #(
  parameter int COLUMNS = lcdsb_pkg::COLUMNS_DEF,
  parameter int ROWS    = lcdsb_pkg::ROWS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire lcdsb_pkg::in_t   in_i,
  input  wire logic             op_pop_i,
  output logic                  op_empty_o,
  output lcdsb_pkg::op_t        op_o
);

  lcdsb_pkg::op_t          op_cls;
  logic                    keep;
  logic                    in_grid;
  logic                    neg;
  logic [$bits(lcdsb_pkg::op_t)-1:0] op_raw;

  assign in_grid = (int'(in_i.column) < COLUMNS) && (int'(in_i.row) < ROWS);
  assign neg     = (lcdsb_pkg::cmd_e'(in_i.cmd) == lcdsb_pkg::CMD_DECIMAL) && in_i.value[31];

  always_comb begin
    op_cls.op       = lcdsb_pkg::OP_TICK;
    op_cls.column   = in_i.column;
    op_cls.row      = in_i.row;
    op_cls.glyph    = in_i.glyph;
    op_cls.count    = in_i.count;
    op_cls.decimals = in_i.decimals;
    op_cls.neg      = neg;
    op_cls.mag      = neg ? (32'd0 - in_i.value) : in_i.value;
    keep            = 1'b0;
    case (lcdsb_pkg::cmd_e'(in_i.cmd))
      lcdsb_pkg::CMD_TICK: begin
        op_cls.op = lcdsb_pkg::OP_TICK;
        keep      = 1'b1;
      end
      lcdsb_pkg::CMD_TOGGLE: begin
        op_cls.op = lcdsb_pkg::OP_TOGGLE;
        keep      = 1'b1;
      end
      lcdsb_pkg::CMD_PUT: begin
        op_cls.op = lcdsb_pkg::OP_PUT;
        keep      = in_grid;
      end
      lcdsb_pkg::CMD_BLINK_RUN: begin
        op_cls.op = lcdsb_pkg::OP_BLINK_RUN;
        keep      = in_grid && (in_i.count != '0);
      end
      lcdsb_pkg::CMD_BLINK_CLR: begin
        op_cls.op = lcdsb_pkg::OP_BLINK_CLR;
        keep      = 1'b1;
      end
      lcdsb_pkg::CMD_UNSIGNED: begin
        op_cls.op = lcdsb_pkg::OP_NUM_U;
        keep      = (in_i.count != '0);
      end
      lcdsb_pkg::CMD_DECIMAL: begin
        op_cls.op = lcdsb_pkg::OP_NUM_D;
        keep      = (in_i.count != '0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // items with no effect are accepted and dropped here
  lcdsb_fifo #(
    .W     ($bits(lcdsb_pkg::op_t)),
    .DEPTH (lcdsb_pkg::FIFO_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .wdata_i (op_cls),
    .full_o  (full_o),
    .pop_i   (op_pop_i),
    .rdata_o (op_raw),
    .empty_o (op_empty_o)
  );

  assign op_o = lcdsb_pkg::op_t'(op_raw);

endmodule

`default_nettype wire

/* rtl/lcdsb_back.sv */
// Back end: shadow buffer, number formatter and refresh scanner.
`default_nettype none

module lcdsb_back #(
  parameter int COLUMNS = lcdsb_pkg::COLUMNS_DEF,
  parameter int ROWS    = lcdsb_pkg::ROWS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            op_empty_i,
  input  wire lcdsb_pkg::op_t  op_i,
  output logic                 op_pop_o,
  input  wire lcdsb_pkg::cfg_t cfg_i,
  input  wire logic            res_full_i,
  output logic                 res_push_o,
  output lcdsb_pkg::out_t      res_o
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SCAN_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_TICK_CMD = 7'b0000010,
    ST_TICK_DAT = 7'b0000100,
    ST_NUM_MUL  = 7'b0001000,
    ST_NUM_DIG  = 7'b0010000,
    ST_NUM_DOT  = 7'b0100000,
    ST_NUM_PAD  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]       glyph_mem [CELLS];
  logic [CELLS-1:0] glyph_vld_q, dirty_q, blink_q, run_mask;
  logic [7:0]       rd_q;
  logic             rd_vld_q;
  logic             phase_q, sub_q;
  logic [SCAN_W-1:0] scan_col_q, tick_col_q;
  logic             scan_row_q, tick_row_q;
  logic [IDX_W-1:0] scan_idx, waddr;

  logic [31:0]       num_q, q32, q_x10, rem32;
  logic [63:0]       prod_q;
  logic signed [5:0] p_q, p1, lo_s;
  logic              lo_q, row_q;
  logic [3:0]        col_q, dcnt_q, dcnt1, dec_q;

  logic       op_go, tick_go;
  logic       mem_we;
  logic [7:0] wdata;
  logic       wr_row;
  logic [5:0] wr_colpos;
  logic       wr_in_grid, p_ok;
  logic [7:0] out_glyph;

  assign op_go   = (state_q == ST_IDLE) && !op_empty_i;
  assign tick_go = op_go && (op_i.op == lcdsb_pkg::OP_TICK);
  assign op_pop_o = op_go;

  assign scan_idx = IDX_W'(int'(scan_row_q) * COLUMNS + int'(scan_col_q));

  assign lo_s  = $signed({5'b0, lo_q});
  assign p_ok  = (p_q >= lo_s);
  assign p1    = p_q - 6'sd1;
  assign dcnt1 = dcnt_q + 4'd1;

  // quotient by 10 from the registered reciprocal product
  assign q32   = {3'b0, prod_q[63:35]};
  assign q_x10 = {q32[28:0], 3'b0} + {q32[30:0], 1'b0};
  assign rem32 = num_q - q_x10;

  assign wr_row    = (state_q == ST_IDLE) ? op_i.row : row_q;
  assign wr_colpos = (state_q == ST_IDLE) ? {2'b0, op_i.column}
                                          : ({2'b0, col_q} + 6'(p_q));
  assign wr_in_grid = (int'(wr_colpos) < COLUMNS) && (int'(wr_row) < ROWS);
  assign waddr      = IDX_W'(int'(wr_row) * COLUMNS + int'(wr_colpos));

  for (genvar j = 0; j < CELLS; j++) begin : g_mask
    localparam int R = j / COLUMNS;
    localparam int C = j % COLUMNS;
    assign run_mask[j] = (int'(op_i.row) == R) && (C >= int'(op_i.column))
                         && (C < int'(op_i.column) + int'(op_i.count));
  end

  assign out_glyph = sub_q ? cfg_i.blink : (rd_vld_q ? rd_q : lcdsb_pkg::SPACE_GLYPH);

  always_comb begin
    state_d    = state_q;
    mem_we     = 1'b0;
    wdata      = op_i.glyph;
    res_push_o = 1'b0;
    res_o.register_select = 1'b0;
    res_o.lcd_byte = lcdsb_pkg::LCD_SET_ADDR | {1'b0, tick_row_q, 6'(tick_col_q)};
    res_o.last     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (op_go) begin
          case (op_i.op)
            lcdsb_pkg::OP_TICK: begin
              if (dirty_q[scan_idx]) begin
                state_d = ST_TICK_CMD;
              end
            end
            lcdsb_pkg::OP_PUT: begin
              mem_we = wr_in_grid;
            end
            lcdsb_pkg::OP_NUM_U: begin
              state_d = ST_NUM_MUL;
            end
            lcdsb_pkg::OP_NUM_D: begin
              mem_we  = wr_in_grid;
              wdata   = op_i.neg ? cfg_i.minus : cfg_i.plus;
              state_d = ST_NUM_MUL;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_TICK_CMD: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_TICK_DAT;
        end
      end
      ST_TICK_DAT: begin
        res_o.register_select = 1'b1;
        res_o.lcd_byte        = out_glyph;
        res_o.last            = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_NUM_MUL: begin
        state_d = ST_NUM_DIG;
      end
      ST_NUM_DIG: begin
        mem_we = p_ok && wr_in_grid;
        wdata  = lcdsb_pkg::DIGIT_ZERO + {4'b0, rem32[3:0]};
        if (lo_q && (dcnt1 == dec_q)) begin
          state_d = ST_NUM_DOT;
        end else if ((q32 != '0) && (p1 >= lo_s)) begin
          state_d = ST_NUM_MUL;
        end else begin
          state_d = ST_NUM_PAD;
        end
      end
      ST_NUM_DOT: begin
        mem_we = p_ok && wr_in_grid;
        wdata  = cfg_i.point;
        if ((num_q != '0) && (p1 >= lo_s)) begin
          state_d = ST_NUM_MUL;
        end else begin
          state_d = ST_NUM_PAD;
        end
      end
      ST_NUM_PAD: begin
        mem_we = p_ok && wr_in_grid;
        wdata  = cfg_i.pad;
        if (!p_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      glyph_vld_q <= '0;
      dirty_q     <= '0;
      blink_q     <= '0;
      phase_q     <= 1'b0;
      scan_col_q  <= '0;
      scan_row_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        glyph_vld_q[waddr] <= 1'b1;
        dirty_q[waddr]     <= 1'b1;
      end
      if (tick_go) begin
        dirty_q[scan_idx] <= 1'b0;
        if (int'(scan_col_q) == COLUMNS - 1) begin
          scan_col_q <= '0;
          scan_row_q <= (int'(scan_row_q) == ROWS - 1) ? 1'b0 : 1'b1;
        end else begin
          scan_col_q <= scan_col_q + SCAN_W'(1);
        end
      end
      if (op_go && (op_i.op == lcdsb_pkg::OP_TOGGLE)) begin
        phase_q <= !phase_q;
      end
      if (op_go && (op_i.op == lcdsb_pkg::OP_BLINK_RUN)) begin
        blink_q <= blink_q | run_mask;
      end
      if (op_go && (op_i.op == lcdsb_pkg::OP_BLINK_CLR)) begin
        blink_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[waddr] <= wdata;
    end
    if (tick_go) begin
      rd_q       <= glyph_mem[scan_idx];
      rd_vld_q   <= glyph_vld_q[scan_idx];
      sub_q      <= blink_q[scan_idx] && phase_q;
      tick_col_q <= scan_col_q;
      tick_row_q <= scan_row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_go) begin
      num_q  <= op_i.mag;
      p_q    <= $signed({1'b0, op_i.count} - 6'd1);
      lo_q   <= (op_i.op == lcdsb_pkg::OP_NUM_D);
      dec_q  <= op_i.decimals;
      dcnt_q <= '0;
      col_q  <= op_i.column;
      row_q  <= op_i.row;
    end
    if (state_q == ST_NUM_MUL) begin
      prod_q <= num_q * lcdsb_pkg::RECIP_10;
    end
    if (state_q == ST_NUM_DIG) begin
      num_q  <= q32;
      dcnt_q <= dcnt1;
      p_q    <= p1;
    end
    if (state_q == ST_NUM_DOT) begin
      p_q <= p1;
    end
    if ((state_q == ST_NUM_PAD) && p_ok) begin
      p_q <= p1;
    end
  end

endmodule

`default_nettype wire

/* bench/char_lcd_shadow_buffer_refresh_tb.sv */
// Self-checking testbench for the character LCD shadow buffer and refresh scanner.
`timescale 1ns / 100ps

module char_lcd_shadow_buffer_refresh_tb;
  import lcdsb_pkg::*;

  localparam int COLUMNS        = COLUMNS_DEF;
  localparam int ROWS           = ROWS_DEF;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int SETTLE_CYCLES  = 200;
  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [7:0] ROW_ADDR_STEP = 8'h40;
  localparam logic [2:0] CMD_UNUSED    = 3'd7;
  localparam logic [2:0] CFG_SPARE_LO  = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI  = 3'd7;
  localparam out_t NO_BYTE = '0;

  typedef struct packed {
    in_t        item;
    logic       typed;
    logic [1:0] n_typed;
    out_t       first;
    out_t       second;
  } dir_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  in_t        in_i        = '0;
  logic       empty;
  logic       pop         = 1'b0;
  out_t       res_o;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = '0;
  logic [7:0] cfg_wdata_i = '0;

  // expectation override that travels with each command transfer
  logic typed_q   = 1'b0;
  int   typed_n_q = 0;
  out_t typed0_q  = '0;
  out_t typed1_q  = '0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic stall_req     = 1'b0;
  logic stall_seen    = 1'b0;
  int   stall_left    = 0;
  int   idle_cycles   = 0;
  int   errors        = 0;

  out_t     lcd_bytes_due [$];
  dir_row_t dir_rows [$];

  // shadow of the block
  logic [7:0] shadow_glyph [CELLS];
  logic       shadow_dirty [CELLS];
  logic       shadow_blink [CELLS];
  int         scan_col;
  int         scan_row;
  logic       blink_on;
  cfg_t       shadow_cfg;

  char_lcd_shadow_buffer_refresh uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic void put_cell(int col, int row, logic [7:0] g);
    if (col < 0 || col >= COLUMNS || row >= ROWS) return;
    shadow_glyph[row * COLUMNS + col] = g;
    shadow_dirty[row * COLUMNS + col] = 1'b1;
  endfunction

  function automatic void put_place(int col, int row, int pos, int lo, int width,
                                    logic [7:0] g);
    if (pos < lo || pos >= width) return;
    put_cell(col + pos, row, g);
  endfunction

  function automatic void write_unsigned(int col, int row, int width, logic [31:0] num);
    int places;
    places = width;
    do begin
      put_place(col, row, places - 1, 0, width, DIGIT_ZERO + 8'(num % 10));
      places--;
      num = num / 10;
    end while (num > 0 && places > 0);
    while (places > 0) begin
      put_place(col, row, places - 1, 0, width, shadow_cfg.pad);
      places--;
    end
  endfunction

  function automatic void write_decimal(int col, int row, int width, int decimals,
                                        logic [31:0] raw);
    logic        neg;
    logic [31:0] num;
    int          places;
    int          dot;
    neg = raw[31];
    num = neg ? 32'd0 - raw : raw;
    if (width <= 0) return;
    put_place(col, row, 0, 0, width, neg ? shadow_cfg.minus : shadow_cfg.plus);
    places = width - 1;
    dot = places;
    do begin
      put_place(col, row, places, 1, width, DIGIT_ZERO + 8'(num % 10));
      places--;
      // separator landing on the sign place is dropped by put_place
      if (dot - places == decimals) begin
        put_place(col, row, places, 1, width, shadow_cfg.point);
        places--;
      end
      num = num / 10;
    end while (num > 0 && places > 0);
    while (places > 0) begin
      put_place(col, row, places, 1, width, shadow_cfg.pad);
      places--;
    end
  endfunction

  // Applies one command to the shadow; returns the number of LCD bytes it emits.
  function automatic int shadow_step(input in_t it, output out_t b0, output out_t b1);
    int         idx;
    int         n;
    logic [7:0] g;
    logic [7:0] addr;
    n = 0;
    b0 = '0;
    b1 = '0;
    case (it.cmd)
      CMD_TICK: begin
        idx = scan_row * COLUMNS + scan_col;
        if (shadow_dirty[idx]) begin
          g = (shadow_blink[idx] && blink_on) ? shadow_cfg.blink : shadow_glyph[idx];
          addr = 8'(scan_row * int'(ROW_ADDR_STEP) + scan_col);
          b0.register_select = 1'b0;
          b0.lcd_byte        = LCD_SET_ADDR | addr;
          b0.last            = 1'b0;
          b1.register_select = 1'b1;
          b1.lcd_byte        = g;
          b1.last            = 1'b1;
          n = 2;
        end
        shadow_dirty[idx] = 1'b0;
        scan_col++;
        if (scan_col >= COLUMNS) begin
          scan_col = 0;
          scan_row++;
          if (scan_row >= ROWS) scan_row = 0;
        end
      end
      CMD_TOGGLE: blink_on = ~blink_on;
      CMD_PUT: put_cell(int'(it.column), int'(it.row), it.glyph);
      CMD_BLINK_RUN: begin
        for (int k = 0; k < int'(it.count); k++) begin
          if (int'(it.column) + k < COLUMNS && int'(it.row) < ROWS)
            shadow_blink[int'(it.row) * COLUMNS + int'(it.column) + k] = 1'b1;
        end
      end
      CMD_BLINK_CLR: begin
        for (int k = 0; k < CELLS; k++) shadow_blink[k] = 1'b0;
      end
      CMD_UNSIGNED: begin
        if (it.count != 0)
          write_unsigned(int'(it.column), int'(it.row), int'(it.count), it.value);
      end
      CMD_DECIMAL: write_decimal(int'(it.column), int'(it.row), int'(it.count),
                                 int'(it.decimals), it.value);
      default: ;
    endcase
    return n;
  endfunction

  function automatic in_t mk(logic [2:0] cmd, logic [3:0] column, logic row,
                             logic [7:0] glyph, logic [4:0] count, logic [3:0] decimals,
                             logic [31:0] value);
    in_t it;
    it.cmd      = cmd;
    it.column   = column;
    it.row      = row;
    it.glyph    = glyph;
    it.count    = count;
    it.decimals = decimals;
    it.value    = value;
    return it;
  endfunction

  function automatic void add_row(in_t it, logic typed, int n, out_t b0, out_t b1);
    dir_row_t r;
    r.item    = it;
    r.typed   = typed;
    r.n_typed = 2'(n);
    r.first   = b0;
    r.second  = b1;
    dir_rows.push_back(r);
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int  pick;
    it = mk(CMD_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
            8'($urandom_range(0, 255)), 5'd0, 4'($urandom_range(0, 15)), 32'd0);
    it.count = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 16))
                                            : 5'($urandom_range(17, 31));
    case ($urandom_range(0, 3))
      0: it.value = $urandom_range(0, 999);
      1: it.value = $urandom;
      2: it.value = 32'd0 - $urandom_range(1, 99999);
      default: begin
        case ($urandom_range(0, 3))
          0: it.value = 32'h0000_0000;
          1: it.value = 32'h8000_0000;
          2: it.value = 32'h7FFF_FFFF;
          default: it.value = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 40)      it.cmd = CMD_TICK;
    else if (pick < 58) it.cmd = CMD_PUT;
    else if (pick < 70) it.cmd = CMD_UNSIGNED;
    else if (pick < 82) it.cmd = CMD_DECIMAL;
    else if (pick < 88) it.cmd = CMD_BLINK_RUN;
    else if (pick < 93) it.cmd = CMD_TOGGLE;
    else if (pick < 97) it.cmd = CMD_BLINK_CLR;
    else                it.cmd = CMD_UNUSED;
    return it;
  endfunction

  task automatic send_item(in_t it, logic typed, int n, out_t b0, out_t b1);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_i      <= it;
    typed_q   <= typed;
    typed_n_q <= n;
    typed0_q  <= b0;
    typed1_q  <= b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_random(int n_items);
    for (int i = 0; i < n_items; i++) send_item(rand_item(), 1'b0, 0, NO_BYTE, NO_BYTE);
    push <= 1'b0;
  endtask

  task automatic settle();
    while (lcd_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_BLINK: shadow_cfg.blink = data;
      CFG_PAD:   shadow_cfg.pad   = data;
      CFG_PLUS:  shadow_cfg.plus  = data;
      CFG_MINUS: shadow_cfg.minus = data;
      CFG_POINT: shadow_cfg.point = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic [7:0] blink, logic [7:0] pad, logic [7:0] plus,
                                logic [7:0] minus, logic [7:0] point);
    write_reg(CFG_BLINK, blink);
    write_reg(CFG_PAD, pad);
    write_reg(CFG_PLUS, plus);
    write_reg(CFG_MINUS, minus);
    write_reg(CFG_POINT, point);
    write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
    write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic flag(string what, logic [7:0] want, logic [7:0] got);
    errors++;
    $display("%0t %s mismatch: expected %02h actual %02h", $time, what, want, got);
  endtask

  // receiver: random pop, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      pop        <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop        <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result check first, then prediction for the command transfer at this edge
  always @(posedge clk_i) begin : scoreboard
    out_t want;
    out_t p0;
    out_t p1;
    int   n;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (lcd_bytes_due.size() == 0) begin
          errors++;
          $display("%0t unexpected transfer: expected none actual rs=%0b byte=%02h last=%0b",
                   $time, res_o.register_select, res_o.lcd_byte, res_o.last);
        end else begin
          want = lcd_bytes_due.pop_front();
          if (res_o.register_select !== want.register_select)
            flag("register_select", 8'(want.register_select), 8'(res_o.register_select));
          if (res_o.lcd_byte !== want.lcd_byte)
            flag("lcd_byte", want.lcd_byte, res_o.lcd_byte);
          if (res_o.last !== want.last)
            flag("last", 8'(want.last), 8'(res_o.last));
        end
      end
      if (push && !full) begin
        n = shadow_step(in_i, p0, p1);
        if (typed_q) begin
          n  = typed_n_q;
          p0 = typed0_q;
          p1 = typed1_q;
        end
        if (n > 0) lcd_bytes_due.push_back(p0);
        if (n > 1) lcd_bytes_due.push_back(p1);
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("char_lcd_shadow_buffer_refresh_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int k = 0; k < CELLS; k++) begin
      shadow_glyph[k] = SPACE_GLYPH;
      shadow_dirty[k] = 1'b0;
      shadow_blink[k] = 1'b0;
    end
    scan_col = 0;
    scan_row = 0;
    blink_on = 1'b0;
    shadow_cfg.blink = BLINK_GLYPH_RST;
    shadow_cfg.pad   = PAD_GLYPH_RST;
    shadow_cfg.plus  = PLUS_GLYPH_RST;
    shadow_cfg.minus = MINUS_GLYPH_RST;
    shadow_cfg.point = POINT_GLYPH_RST;

    add_row(mk(CMD_TICK, 0, 0, 8'h00, 0, 0, 0), 1'b1, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_PUT, 1, 0, 8'hFF, 0, 0, 0), 1'b1, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_TICK, 0, 0, 8'h00, 0, 0, 0), 1'b1, 2,
            '{1'b0, LCD_SET_ADDR | 8'h01, 1'b0}, '{1'b1, 8'hFF, 1'b1});
    add_row(mk(CMD_PUT, 15, 1, 8'h00, 0, 0, 0), 1'b1, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_UNSIGNED, 2, 0, 8'h00, 16, 0, 32'hFFFF_FFFF), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_DECIMAL, 0, 1, 8'h00, 16, 15, 32'h8000_0000), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_DECIMAL, 4, 1, 8'h00, 3, 2, 32'd12345), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_DECIMAL, 8, 1, 8'h00, 7, 2, 32'hFFFF_CFC7), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_UNSIGNED, 0, 0, 8'h00, 0, 0, 32'd12), 1'b1, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_DECIMAL, 0, 0, 8'h00, 0, 0, 32'd7), 1'b1, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_UNSIGNED, 14, 1, 8'h00, 31, 0, 32'd0), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_UNSIGNED, 12, 0, 8'h00, 4, 0, 32'd7), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_DECIMAL, 10, 0, 8'h00, 6, 0, 32'd0), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_BLINK_RUN, 10, 0, 8'h00, 16, 0, 0), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_TOGGLE, 0, 0, 8'h00, 0, 0, 0), 1'b1, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_UNUSED, 15, 1, 8'hFF, 31, 15, 32'hFFFF_FFFF), 1'b1, 0, NO_BYTE, NO_BYTE);
    for (int k = 0; k < 4; k++)
      add_row(mk(CMD_TICK, 0, 0, 8'h00, 0, 0, 0), 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(mk(CMD_BLINK_CLR, 0, 0, 8'h00, 0, 0, 0), 1'b1, 0, NO_BYTE, NO_BYTE);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 61;
    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].n_typed,
                dir_rows[i].first, dir_rows[i].second);
    send_random(450);

    settle();
    write_all_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    send_idle_pct = 61;
    recv_idle_pct = 33;
    send_random(450);

    settle();
    write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(250);

    settle();
    write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_random(200);

    // back-pressure: dirty every cell, then tick against a stalled receiver
    send_item(mk(CMD_UNSIGNED, 0, 0, 8'h00, 16, 0, $urandom), 1'b0, 0, NO_BYTE, NO_BYTE);
    send_item(mk(CMD_DECIMAL, 0, 1, 8'h00, 16, 3, $urandom), 1'b0, 0, NO_BYTE, NO_BYTE);
    send_item(mk(CMD_BLINK_RUN, 4, 1, 8'h00, 8, 0, 0), 1'b0, 0, NO_BYTE, NO_BYTE);
    stall_req <= ~stall_req;
    for (int i = 0; i < 40; i++)
      send_item(mk(CMD_TICK, 0, 0, 8'h00, 0, 0, 0), 1'b0, 0, NO_BYTE, NO_BYTE);
    push <= 1'b0;
    while (lcd_bytes_due.size() != 0) @(posedge clk_i);
    send_random(60);

    while (lcd_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("char_lcd_shadow_buffer_refresh_tb: PASS");
    end else begin
      $display("char_lcd_shadow_buffer_refresh_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lcdsb_pkg.sv
rtl/lcdsb_fifo.sv
rtl/lcdsb_front.sv
rtl/lcdsb_back.sv
rtl/char_lcd_shadow_buffer_refresh.sv
bench/char_lcd_shadow_buffer_refresh_tb.sv
